// ===== sv/mi4_pkg.sv =====
// Shared types, constants and index functions for the 4x4 matrix inverse.
// Used by mi4_mul, mi4_div and matrix_inverse_4x4; depends on nothing.
package mi4_pkg;

  localparam int DEF_ENTRY_BITS = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int OUT_BITS       = 32;
  localparam int IN_BITS        = 32;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD0,
    S_GET0,
    S_GET1,
    S_MUL1,
    S_MUL2,
    S_DRD,
    S_DMUL,
    S_DWAIT,
    S_CHK,
    S_QRD,
    S_QDIV,
    S_QWAIT,
    S_EMIT
  } mi4_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } mi4_unit_ctl_t;

  // Column picked for minor row k by permutation p of {0,1,2}.
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] k);
    logic [5:0] cols;
    case (p)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    case (k)
      2'd0:    perm_col = cols[1:0];
      2'd1:    perm_col = cols[3:2];
      default: perm_col = cols[5:4];
    endcase
  endfunction

  function automatic logic perm_neg(input logic [2:0] p);
    perm_neg = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // Matrix address of factor k of term p in the minor that strikes row and column of ci.
  function automatic logic [3:0] minor_addr(input logic [3:0] ci, input logic [2:0] p,
                                            input logic [1:0] k);
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] j;
    j   = perm_col(p, k);
    row = (k >= ci[3:2]) ? k + 2'd1 : k;
    col = (j >= ci[1:0]) ? j + 2'd1 : j;
    minor_addr = {row, col};
  endfunction

endpackage

// ===== sv/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse by adjugate and cofactors in fixed point, top level.
// Depends on mi4_pkg, mi4_mul and mi4_div.
//
//  channel | direction | handshake               | fields
//  in      | input     | in_valid_i, in_stall_o  | entry_value_i
//  out     | output    | out_valid_o, out_stall_i| inverse_value_o, entry_index_o,
//          |           |                         | singular_o, clipped_o, last_o
//
// Sixteen words load first. The shift-add multiplier forms each of the 96 cofactor terms
// as two products, and four more products give the determinant. Each result then waits
// on the restoring divider before it is emitted.
// Reset clears the sequencer and the load count; the matrix store needs no clearing.
// A stalled output word holds, and the sequencer waits only when a new result is ready.
module matrix_inverse_4x4 #(
  parameter int ENTRY_BITS = mi4_pkg::DEF_ENTRY_BITS,
  parameter int FRAC_BITS  = mi4_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mi4_pkg::IN_BITS-1:0] entry_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mi4_pkg::OUT_BITS-1:0] inverse_value_o,
  output logic [3:0]                         entry_index_o,
  output logic                               singular_o,
  output logic                               clipped_o,
  output logic                               last_o
);

  localparam int E   = ENTRY_BITS;
  localparam int CW  = 3 * E + 3;
  localparam int DW  = 4 * E + 5;
  localparam int NW  = CW + 2 * FRAC_BITS;
  localparam int IW  = (E > mi4_pkg::IN_BITS) ? E : mi4_pkg::IN_BITS;
  localparam int OW  = mi4_pkg::OUT_BITS;

  mi4_pkg::mi4_state_e state_q, state_d;

  logic [E-1:0]  mstore [16];
  logic [CW-1:0] cstore [16];
  logic [E-1:0]  mrd_q;
  logic [CW-1:0] crd_q;
  logic [3:0]    raddr, craddr;

  logic [3:0]    load_cnt_q, ci_q, oi_q;
  logic [2:0]    p_q;
  logic [1:0]    dc_q;
  logic          sing_q, rneg_q, out_valid_q;
  logic [DW-1:0] t_q, det_q;
  logic [CW-1:0] acc_q;
  logic [IW-1:0] in_ext;

  mi4_pkg::mi4_unit_ctl_t mul_ci, mul_co, div_ci, div_co;
  logic [DW-1:0] mul_x, mul_prod;
  logic [E-1:0]  mul_y;
  logic [NW-1:0] div_num;
  logic [DW-1:0] dmag;
  logic [CW-1:0] cmag, term, cof_new;
  logic [OW-1:0] div_quot, limit, val;
  logic          div_high, over, emit_load, in_acc, out_acc, term_neg, last_now;

  assign in_ext   = IW'($unsigned(entry_value_i));
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign last_now = sing_q || (oi_q == 4'd15);

  assign term     = mul_prod[CW-1:0];
  assign term_neg = mi4_pkg::perm_neg(p_q) ^ ci_q[2] ^ ci_q[0];
  assign cof_new  = acc_q + (term_neg ? -term : term);
  assign dmag     = det_q[DW-1] ? -det_q : det_q;
  assign cmag     = crd_q[CW-1] ? -crd_q : crd_q;
  assign div_num  = NW'(cmag) << (2 * FRAC_BITS);

  assign limit = rneg_q ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  assign over  = div_high || (div_quot > limit);
  assign val   = over ? (rneg_q ? limit : limit) : div_quot;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mi4_pkg::S_LOAD:  if (in_acc && load_cnt_q == 4'd15) state_d = mi4_pkg::S_RD0;
      mi4_pkg::S_RD0:   state_d = mi4_pkg::S_GET0;
      mi4_pkg::S_GET0:  state_d = mi4_pkg::S_GET1;
      mi4_pkg::S_GET1:  state_d = mi4_pkg::S_MUL1;
      mi4_pkg::S_MUL1:  if (mul_co.done) state_d = mi4_pkg::S_MUL2;
      mi4_pkg::S_MUL2: begin
        if (mul_co.done) begin
          if (p_q != 3'd5) state_d = mi4_pkg::S_RD0;
          else if (ci_q == 4'd15) state_d = mi4_pkg::S_DRD;
          else state_d = mi4_pkg::S_RD0;
        end
      end
      mi4_pkg::S_DRD:   state_d = mi4_pkg::S_DMUL;
      mi4_pkg::S_DMUL:  state_d = mi4_pkg::S_DWAIT;
      mi4_pkg::S_DWAIT: begin
        if (mul_co.done) state_d = (dc_q == 2'd3) ? mi4_pkg::S_CHK : mi4_pkg::S_DRD;
      end
      mi4_pkg::S_CHK:   state_d = (det_q == '0) ? mi4_pkg::S_EMIT : mi4_pkg::S_QRD;
      mi4_pkg::S_QRD:   state_d = mi4_pkg::S_QDIV;
      mi4_pkg::S_QDIV:  state_d = mi4_pkg::S_QWAIT;
      mi4_pkg::S_QWAIT: if (div_co.done) state_d = mi4_pkg::S_EMIT;
      mi4_pkg::S_EMIT: begin
        if (emit_load) state_d = last_now ? mi4_pkg::S_LOAD : mi4_pkg::S_QRD;
      end
      default: state_d = mi4_pkg::S_LOAD;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    raddr        = '0;
    craddr       = '0;
    mul_ci.start = 1'b0;
    mul_ci.done  = 1'b0;
    div_ci.start = 1'b0;
    div_ci.done  = 1'b0;
    mul_x        = t_q;
    mul_y        = mrd_q;
    emit_load    = 1'b0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      mi4_pkg::S_LOAD:  in_stall_o = 1'b0;
      mi4_pkg::S_RD0:   raddr = mi4_pkg::minor_addr(ci_q, p_q, 2'd0);
      mi4_pkg::S_GET0:  raddr = mi4_pkg::minor_addr(ci_q, p_q, 2'd1);
      mi4_pkg::S_GET1: begin
        raddr        = mi4_pkg::minor_addr(ci_q, p_q, 2'd2);
        mul_ci.start = 1'b1;
      end
      mi4_pkg::S_MUL1: begin
        raddr        = mi4_pkg::minor_addr(ci_q, p_q, 2'd2);
        mul_x        = mul_prod;
        mul_ci.start = mul_co.done;
      end
      mi4_pkg::S_MUL2:  raddr = mi4_pkg::minor_addr(ci_q, p_q, 2'd2);
      mi4_pkg::S_DRD: begin
        raddr  = {2'd0, dc_q};
        craddr = {2'd0, dc_q};
      end
      mi4_pkg::S_DMUL: begin
        mul_x        = {{(DW-CW){crd_q[CW-1]}}, crd_q};
        mul_ci.start = 1'b1;
      end
      mi4_pkg::S_DWAIT: ;
      mi4_pkg::S_CHK:   ;
      mi4_pkg::S_QRD:   craddr = {oi_q[1:0], oi_q[3:2]};
      mi4_pkg::S_QDIV: begin
        craddr       = {oi_q[1:0], oi_q[3:2]};
        div_ci.start = 1'b1;
      end
      mi4_pkg::S_QWAIT: ;
      mi4_pkg::S_EMIT:  emit_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mi4_pkg::S_LOAD;
      load_cnt_q  <= '0;
      ci_q        <= '0;
      p_q         <= '0;
      dc_q        <= '0;
      oi_q        <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) load_cnt_q <= load_cnt_q + 1'b1;
      if (state_q == mi4_pkg::S_MUL2 && mul_co.done) begin
        p_q <= (p_q == 3'd5) ? 3'd0 : p_q + 1'b1;
        if (p_q == 3'd5) ci_q <= ci_q + 1'b1;
      end
      if (state_q == mi4_pkg::S_DWAIT && mul_co.done) dc_q <= dc_q + 1'b1;
      if (state_q == mi4_pkg::S_CHK) begin
        sing_q <= (det_q == '0);
        oi_q   <= '0;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
        if (!last_now) oi_q <= oi_q + 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) mstore[load_cnt_q] <= in_ext[E-1:0];
    mrd_q <= mstore[raddr];
    if (state_q == mi4_pkg::S_MUL2 && mul_co.done && p_q == 3'd5) cstore[ci_q] <= cof_new;
    crd_q <= cstore[craddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mi4_pkg::S_GET0) t_q <= {{(DW-E){mrd_q[E-1]}}, mrd_q};
    if (state_q == mi4_pkg::S_MUL2 && mul_co.done) acc_q <= (p_q == 3'd5) ? '0 : cof_new;
    if (in_acc && load_cnt_q == 4'd15) begin
      acc_q <= '0;
      det_q <= '0;
    end
    if (state_q == mi4_pkg::S_DWAIT && mul_co.done) det_q <= det_q + mul_prod;
    if (state_q == mi4_pkg::S_QDIV) rneg_q <= crd_q[CW-1] ^ det_q[DW-1];
    if (emit_load) begin
      entry_index_o <= sing_q ? 4'd0 : oi_q;
      singular_o    <= sing_q;
      clipped_o     <= !sing_q && over;
      last_o        <= last_now;
      inverse_value_o <= sing_q ? '0 : (rneg_q ? -val : val);
    end
  end

  mi4_mul #(.EW(E), .MW(DW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ci),
    .ctl_o  (mul_co),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .prod_o (mul_prod)
  );

  mi4_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ci),
    .ctl_o  (div_co),
    .num_i  (div_num),
    .den_i  (dmag),
    .quot_o (div_quot),
    .high_o (div_high)
  );

  assign out_valid_o = out_valid_q;

  a_load_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mi4_pkg::S_LOAD) |-> (load_cnt_q == 4'd0))
    else $error("load count nonzero outside loading");

  a_singular_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (inverse_value_o == '0 && last_o && !clipped_o
                                     && entry_index_o == 4'd0))
    else $error("bad singular word");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ci.start |-> (det_q != '0))
    else $error("division by a zero determinant");

endmodule

// ===== sv/mi4_mul.sv =====
// Shared shift-add multiplier: wide signed word times a signed entry, one bit a cycle.
// Depends on mi4_pkg.
module mi4_mul #(
  parameter int EW = mi4_pkg::DEF_ENTRY_BITS,
  parameter int MW = 4 * mi4_pkg::DEF_ENTRY_BITS + 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mi4_pkg::mi4_unit_ctl_t ctl_i,
  output mi4_pkg::mi4_unit_ctl_t ctl_o,
  input  logic [MW-1:0]        x_i,
  input  logic [EW-1:0]        y_i,
  output logic [MW-1:0]        prod_o
);

  localparam int CNTW = $clog2(EW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [MW-1:0]   acc_q, x_q;
  logic [EW-1:0]   mag_q;
  logic            neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(EW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q <= '0;
      x_q   <= x_i;
      neg_q <= y_i[EW-1];
      mag_q <= y_i[EW-1] ? -y_i : y_i;
    end else if (busy_q) begin
      acc_q <= (acc_q << 1) + (mag_q[EW-1] ? x_q : '0);
      mag_q <= mag_q << 1;
    end
  end

  assign prod_o      = neg_q ? -acc_q : acc_q;
  assign ctl_o.done  = done_q;
  assign ctl_o.start = busy_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("multiplier started while busy");

endmodule

// ===== sv/mi4_div.sv =====
// Shared restoring divider, one quotient bit a cycle, keeping the low 32 quotient bits
// and a flag for any higher one. Depends on mi4_pkg.
module mi4_div #(
  parameter int NW = 3 * mi4_pkg::DEF_ENTRY_BITS + 3 + 2 * mi4_pkg::DEF_FRAC_BITS,
  parameter int DW = 4 * mi4_pkg::DEF_ENTRY_BITS + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mi4_pkg::mi4_unit_ctl_t        ctl_i,
  output mi4_pkg::mi4_unit_ctl_t        ctl_o,
  input  logic [NW-1:0]                 num_i,
  input  logic [DW-1:0]                 den_i,
  output logic [mi4_pkg::OUT_BITS-1:0]  quot_o,
  output logic                          high_o
);

  localparam int CNTW = $clog2(NW + 1);
  localparam int QW   = mi4_pkg::OUT_BITS;

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q, rem_q, sh;
  logic [QW-1:0]   quot_q;
  logic            high_q, ge;

  assign sh = {rem_q[DW-2:0], num_q[NW-1]};
  assign ge = (sh >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      high_q <= 1'b0;
    end else if (busy_q) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? sh - den_q : sh;
      quot_q <= {quot_q[QW-2:0], ge};
      high_q <= high_q | quot_q[QW-1];
    end
  end

  assign quot_o      = quot_q;
  assign high_o      = high_q;
  assign ctl_o.done  = done_q;
  assign ctl_o.start = busy_q;

endmodule
